// ===== rtl/packed_raw_pixel_unpacker_assert.svh =====
// Assertion macros for the packed raw pixel unpacker checker.
`ifndef PACKED_RAW_PIXEL_UNPACKER_ASSERT_SVH
`define PACKED_RAW_PIXEL_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define PRPU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prpu assertion failed");

// Next-cycle implication, disabled while rst is high.
`define PRPU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prpu assertion failed");

`endif

// ===== rtl/prpu_pkg.sv =====
// Package: types and constants of the packed raw pixel unpacker.
`timescale 1ns / 1ps
package prpu_pkg;

   localparam int WORD_BITS     = 16;
   localparam int STORE_BITS    = 15;
   localparam int COUNT_BITS    = 4;
   localparam int WIDTH_BITS    = 5;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [WIDTH_BITS-1:0]    SAMPLE_BITS_RESET = 5'd14;
   localparam logic [WIDTH_BITS-1:0]    SAMPLE_BITS_MIN   = 5'd8;
   localparam logic [WIDTH_BITS-1:0]    SAMPLE_BITS_MAX   = 5'd16;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SAMPLE_BITS   = 2'd0;

   typedef struct packed {
      logic [WORD_BITS-1:0] sample;
      logic                 last_of_run;
   } entry_type;

   // One accepted word's results, handed from the unpacker to the queue.
   typedef struct packed {
      logic                 valid;
      logic                 two;
      logic [WORD_BITS-1:0] first;
      logic [WORD_BITS-1:0] second;
   } push_type;

endpackage

// ===== rtl/prpu_req_if.sv =====
// Interfaces: packed word channel and unpacked sample channel.
`timescale 1ns / 1ps
interface prpu_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] packed_word;
   logic        frame_start;

   modport source (output valid, output packed_word, output frame_start, input ready);
   modport sink   (input valid, input packed_word, input frame_start, output ready);
endinterface

interface prpu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample;
   logic        last_of_run;

   modport source (output valid, output sample, output last_of_run, input ready);
   modport sink   (input valid, input sample, input last_of_run, output ready);
endinterface

// ===== rtl/prpu_csr.sv =====
// Configuration register block: sample width register on an APB-style port.
`timescale 1ns / 1ps
module prpu_csr
   import prpu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [WIDTH_BITS-1:0]    sample_bits
);

   logic [WIDTH_BITS-1:0] sample_bits_ff;
   logic [WIDTH_BITS-1:0] sample_bits_in;
   logic                  wr_sample_bits;

   assign csr_pready     = 1'b1;
   assign wr_sample_bits = csr_psel && csr_penable && csr_pwrite && csr_pready
                           && (csr_paddr == REG_SAMPLE_BITS);
   assign sample_bits_in = wr_sample_bits ? csr_pwdata[WIDTH_BITS-1:0] : sample_bits_ff;
   assign sample_bits    = sample_bits_ff;

   always_comb begin
      unique case (csr_paddr)
         REG_SAMPLE_BITS: csr_prdata = {{(CSR_DATA_BITS-WIDTH_BITS){1'b0}}, sample_bits_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bits_ff <= SAMPLE_BITS_RESET;
      end else begin
         sample_bits_ff <= sample_bits_in;
      end
   end

endmodule

// ===== rtl/prpu_unpack.sv =====
// Bit accumulator: appends a word and cuts one or two samples off the top.
`timescale 1ns / 1ps
module prpu_unpack
   import prpu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WIDTH_BITS-1:0] sample_bits,
   input  logic                  accept,
   input  logic [WORD_BITS-1:0]  packed_word,
   input  logic                  frame_start,
   output push_type              push
);

   logic [STORE_BITS-1:0]           store_ff, store_in;
   logic [COUNT_BITS-1:0]           count_ff, count_in;
   logic [WIDTH_BITS-1:0]           width;
   logic [STORE_BITS-1:0]           base_store;
   logic [COUNT_BITS-1:0]           base_count;
   logic [STORE_BITS+WORD_BITS-1:0] ext;
   logic [WIDTH_BITS-1:0]           cnt, c1, c2, rem;
   logic [WIDTH_BITS-1:0]           mask_shift;
   logic [WORD_BITS-1:0]            smask;
   logic [STORE_BITS+WORD_BITS-1:0] sh0, sh1;
   logic                            two;

   always_comb begin
      if (sample_bits < SAMPLE_BITS_MIN) begin
         width = SAMPLE_BITS_MIN;
      end else if (sample_bits > SAMPLE_BITS_MAX) begin
         width = SAMPLE_BITS_MAX;
      end else begin
         width = sample_bits;
      end
   end

   assign base_store = frame_start ? '0 : store_ff;
   assign base_count = frame_start ? '0 : count_ff;
   assign ext        = {base_store, packed_word};
   // count plus one word, always 16..31
   assign cnt        = {1'b1, base_count};
   assign c1         = cnt - width;
   assign two        = (c1 >= width);
   assign c2         = c1 - width;
   assign rem        = two ? c2 : c1;
   assign mask_shift = SAMPLE_BITS_MAX - width;
   assign smask      = {WORD_BITS{1'b1}} >> mask_shift;
   assign sh0        = ext >> c1;
   assign sh1        = ext >> c2;

   assign store_in = accept
                     ? (ext[STORE_BITS-1:0]
                        & ((STORE_BITS'(1) << rem[COUNT_BITS-1:0]) - STORE_BITS'(1)))
                     : store_ff;
   assign count_in = accept ? rem[COUNT_BITS-1:0] : count_ff;

   assign push.valid  = accept;
   assign push.two    = two;
   assign push.first  = sh0[WORD_BITS-1:0] & smask;
   assign push.second = sh1[WORD_BITS-1:0] & smask;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
      end else begin
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/prpu_queue.sv =====
// Result queue: takes one or two samples per word, delivers one per transfer.
`timescale 1ns / 1ps
module prpu_queue
   import prpu_pkg::*;
#(
   parameter int DEPTH = 4
)(
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [WORD_BITS-1:0] out_sample,
   output logic                 out_last_of_run
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       push_n;
   logic                   pop;
   entry_type              e0, e1;

   assign pop        = out_valid && out_ready;
   assign push_n     = push.valid ? (push.two ? CNT_W'(2) : CNT_W'(1)) : '0;
   assign push_ready = (count_ff <= CNT_W'(DEPTH - 2));
   assign wr_ptr_nx  = PTR_W'(wr_ptr_ff + 1'b1);
   assign wr_ptr_in  = PTR_W'(wr_ptr_ff + push_n);
   assign rd_ptr_in  = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in   = CNT_W'(count_ff + push_n - (pop ? CNT_W'(1) : CNT_W'(0)));

   assign e0.sample       = push.first;
   assign e0.last_of_run  = !push.two;
   assign e1.sample       = push.second;
   assign e1.last_of_run  = 1'b1;

   assign out_valid       = (count_ff != '0);
   assign out_sample      = mem_ff[rd_ptr_ff].sample;
   assign out_last_of_run = mem_ff[rd_ptr_ff].last_of_run;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= e0;
         if (push.two) begin
            mem_ff[wr_ptr_nx] <= e1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/packed_raw_pixel_unpacker.sv =====
// Top level: unpacks MSB-first packed raw samples from 16-bit words.
// One packed word is taken per cycle while req_ready is high; it is appended to the
// leftover bits and one or two samples of sample_bits width (clamped to 8..16) are cut off
// in the same cycle and pushed into a QUEUE_DEPTH-entry result queue (QUEUE_DEPTH a power
// of two, at least 2) that hands them to rsp in order. The result side delivers one sample
// per cycle while rsp_ready is high, so a word that yields two samples takes two transfers;
// req_ready stays high while the queue holds at most QUEUE_DEPTH-2 samples, whatever
// rsp_ready does. frame_start drops the leftover bits before its word. sample_bits is
// written at byte address 0 of the csr port and should only change while the block is idle.
`timescale 1ns / 1ps
module packed_raw_pixel_unpacker
   import prpu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)(
   input  logic                     clock,
   input  logic                     reset,
   prpu_req_if.sink                 req,
   prpu_rsp_if.source               rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [WIDTH_BITS-1:0] sample_bits;
   logic                  accept;
   logic                  push_ready;
   push_type              push;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   prpu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .sample_bits (sample_bits)
   );

   prpu_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .sample_bits (sample_bits),
      .accept      (accept),
      .packed_word (req.packed_word),
      .frame_start (req.frame_start),
      .push        (push)
   );

   prpu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_ready      (push_ready),
      .out_valid       (rsp.valid),
      .out_ready       (rsp.ready),
      .out_sample      (rsp.sample),
      .out_last_of_run (rsp.last_of_run)
   );

endmodule

// ===== rtl/prpu_checker.sv =====
// Port-level checker for the packed raw pixel unpacker, with its bind.
`timescale 1ns / 1ps
`include "packed_raw_pixel_unpacker_assert.svh"
module prpu_checker
   import prpu_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [WORD_BITS-1:0]     rsp_sample,
   input logic                     rsp_last_of_run,
   input logic                     csr_psel,
   input logic                     csr_penable,
   input logic                     csr_pwrite,
   input logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input logic [CSR_DATA_BITS-1:0] csr_prdata
);

   logic rsp_stall;
   logic rsp_first_of_pair;
   logic csr_wr_width;

   assign rsp_stall         = rsp_valid && !rsp_ready;
   assign rsp_first_of_pair = rsp_valid && rsp_ready && !rsp_last_of_run;
   assign csr_wr_width      = csr_psel && csr_penable && csr_pwrite
                              && (csr_paddr == REG_SAMPLE_BITS);

   `PRPU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_sample) && $stable(rsp_last_of_run))
   `PRPU_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_first_of_pair, rsp_valid)
   `PRPU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `PRPU_ASSERT_NEXT(a_width_readback, clock, reset, csr_wr_width, (csr_paddr != REG_SAMPLE_BITS) || (csr_prdata[WIDTH_BITS-1:0] == $past(csr_pwdata[WIDTH_BITS-1:0])))

endmodule

bind packed_raw_pixel_unpacker prpu_checker u_prpu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_sample      (rsp.sample),
   .rsp_last_of_run (rsp.last_of_run),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_pwdata      (csr_pwdata),
   .csr_prdata      (csr_prdata)
);

// ===== verif/packed_raw_pixel_unpacker_tb.sv =====
// Testbench: checks the packed raw pixel unpacker against its own bit-exact predictor.
`timescale 1ns / 1ps
module packed_raw_pixel_unpacker_tb;
   import prpu_pkg::*;

   localparam int IDLE_PCT       = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASES         = 12;
   localparam int PHASE_WORDS    = 75;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   prpu_req_if req_ch();
   prpu_rsp_if rsp_ch();

   packed_raw_pixel_unpacker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [30:0]           pred_bits;
   logic [4:0]            pred_count;
   logic [WIDTH_BITS-1:0] width_reg;
   entry_type             pending_samples[$];
   entry_type             oldest;

   int words_sent;
   int samples_checked;
   int width_writes;
   int error_count;
   int stall_cycles;
   bit steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamped_width(input logic [WIDTH_BITS-1:0] value);
      if (value < SAMPLE_BITS_MIN) return int'(SAMPLE_BITS_MIN);
      if (value > SAMPLE_BITS_MAX) return int'(SAMPLE_BITS_MAX);
      return int'(value);
   endfunction

   function automatic void unpack_word(input logic [15:0] word, input bit start);
      int          w;
      int          n;
      int          cnt;
      logic [31:0] acc;
      logic [15:0] cut[2];
      entry_type   e;
      w   = clamped_width(width_reg);
      n   = 0;
      acc = start ? 32'd0 : {1'b0, pred_bits};
      cnt = start ? 0 : int'(pred_count);
      acc = ((acc << 16) | {16'd0, word}) & 32'h7FFF_FFFF;
      cnt = cnt + 16;
      while (n < 2 && cnt >= w) begin
         cnt    = cnt - w;
         cut[n] = 16'((acc >> cnt) & ((32'd1 << w) - 32'd1));
         n++;
      end
      acc = acc & ((32'd1 << cnt) - 32'd1);
      for (int i = 0; i < n; i++) begin
         e.sample      = cut[i];
         e.last_of_run = (i == n - 1);
         pending_samples.push_back(e);
      end
      pred_bits  = acc[30:0];
      pred_count = 5'(cnt);
   endfunction

   task automatic send_word(input logic [15:0] word, input bit start);
      int gap;
      gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(3, 1) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.packed_word <= word;
      req_ch.frame_start <= start;
      do @(posedge clock); while (!req_ch.ready);
      unpack_word(word, start);
      words_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      wait_idle();
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= REG_SAMPLE_BITS;
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      width_reg = value;
      width_writes++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[WIDTH_BITS-1:0] !== value) begin
         error_count++;
         $display("%0t: sample_bits readback expected %0d actual %0d",
                  $time, value, readback[WIDTH_BITS-1:0]);
      end
   endtask

   // reset width of 14, leftover grows by two bits per word until the last word yields two samples
   task automatic test_reset_width();
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'hAAAA, 1'b0);
      send_word(16'h5555, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h8001, 1'b0);
      send_word(16'h7FFE, 1'b0);
   endtask

   // no leftover bits remain when width 8 is set: each word yields exactly two samples
   task automatic test_width_change();
      write_width(5'd8);
      send_word(16'h0F0F, 1'b0);
      send_word(16'hFFFF, 1'b0);
   endtask

   task automatic test_width_extremes();
      logic [WIDTH_BITS-1:0] widths[7];
      widths = '{5'd16, 5'd10, 5'd12, 5'd7, 5'd0, 5'd17, 5'd31};
      foreach (widths[i]) begin
         write_width(widths[i]);
         send_word(16'hFFFF, 1'b1);
         send_word(16'($urandom_range(65535)), 1'b0);
      end
   endtask

   task automatic test_random_stream();
      logic [WIDTH_BITS-1:0] value;
      logic [15:0]           word;
      int                    pick;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: value = SAMPLE_BITS_MIN;
            1: value = SAMPLE_BITS_MAX;
            2: value = 5'd31;
            3: value = 5'd0;
            default: begin
               if ($urandom_range(99) < 80) value = 5'($urandom_range(16, 8));
               else value = 5'($urandom_range(31));
            end
         endcase
         write_width(value);
         steady = (phase == 5);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) word = 16'h0000;
            else if (pick < 16) word = 16'hFFFF;
            else word = 16'($urandom_range(65535));
            send_word(word, $urandom_range(99) < 4);
         end
         steady = 1'b0;
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            error_count++;
            $display("%0t: unexpected sample: expected none, actual sample %h last %b",
                     $time, rsp_ch.sample, rsp_ch.last_of_run);
         end else begin
            oldest = pending_samples.pop_front();
            samples_checked++;
            if (rsp_ch.sample !== oldest.sample) begin
               error_count++;
               $display("%0t: sample expected %h actual %h",
                        $time, oldest.sample, rsp_ch.sample);
            end
            if (rsp_ch.last_of_run !== oldest.last_of_run) begin
               error_count++;
               $display("%0t: last_of_run expected %b actual %b",
                        $time, oldest.last_of_run, rsp_ch.last_of_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                     $time, stall_cycles, pending_samples.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.packed_word = 16'd0;
      req_ch.frame_start = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      pred_bits          = '0;
      pred_count         = '0;
      width_reg          = SAMPLE_BITS_RESET;
      words_sent         = 0;
      samples_checked    = 0;
      width_writes       = 0;
      error_count        = 0;
      steady             = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_width();
      test_width_change();
      test_width_extremes();
      test_random_stream();
      wait_idle();

      $display("Run covered %0d packed words and %0d checked samples over %0d width writes,",
               words_sent, samples_checked, width_writes);
      $display("with out-of-range widths, width changes mid-stream and frame restarts.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
